// ===== rtl/oate_pkg.sv =====
// ----------------------------------------------------------------------------
// oate_pkg: shared types and constants of the ordered array table engine
// Sizes, command and status codes, sequencer states and the key memory port.
// ----------------------------------------------------------------------------
package oate_pkg;

	localparam int DEPTH  = 32;
	localparam int KEY_W  = 64;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	// fixed field widths of the stream beats
	localparam int CMD_W     = 3;
	localparam int POS_W     = 6;
	localparam int POSB_W    = 5;
	localparam int VAL_W     = 64;
	localparam int STAT_W    = 3;
	localparam int IDX_W     = 5;
	localparam int CNT_OUT_W = 6;

	// width that holds both a position and the fill count for compares
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam int IN_BITS    = POS_W + POSB_W + VAL_W;
	localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS   = VAL_W + IDX_W + CNT_OUT_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_DISPLAY = 3'd0,
		CMD_INSERT  = 3'd1,
		CMD_DELETE  = 3'd2,
		CMD_SWAP    = 3'd3,
		CMD_REVERSE = 3'd4,
		CMD_FIND    = 3'd5
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 3'd0,
		ST_BADPOS   = 3'd1,
		ST_NOTFOUND = 3'd2,
		ST_FULL     = 3'd3,
		ST_BADCMD   = 3'd4,
		ST_EMPTY    = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISP,
		S_FIND,
		S_MOVE,
		S_PUT,
		S_RLO,
		S_RHI,
		S_WLO,
		S_WHI,
		S_RESP
	} state_t;

	typedef struct packed {
		logic              re;
		logic [ADDR_W-1:0] raddr;
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [KEY_W-1:0]  wdata;
	} ram_req_t;

endpackage

// ===== rtl/oate_ram.sv =====
// ----------------------------------------------------------------------------
// oate_ram: key memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module oate_ram (
	input  logic                     clk,
	input  oate_pkg::ram_req_t       req,
	output logic [oate_pkg::KEY_W-1:0] rdata
);

	logic [oate_pkg::KEY_W-1:0] mem [oate_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

// ===== rtl/oate_seq.sv =====
// ----------------------------------------------------------------------------
// oate_seq: command sequencer
// Decodes command beats, walks the key memory and drives the result register.
// ----------------------------------------------------------------------------
module oate_seq (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// position, position_b, key_value (low bits first)
	input  logic [oate_pkg::IN_DATA_W-1:0]    s_tdata,
	// cmd
	input  logic [oate_pkg::CMD_W-1:0]        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// read_value, index, item_count (low bits first)
	output logic [oate_pkg::OUT_DATA_W-1:0]   m_tdata,
	// status
	output logic [oate_pkg::STAT_W-1:0]       m_tuser,
	output logic                              m_tlast,
	output oate_pkg::ram_req_t                ram_req,
	input  logic [oate_pkg::KEY_W-1:0]        ram_rdata
);

	oate_pkg::state_t state_q, state_d;

	logic [oate_pkg::CNT_W-1:0]  fill_q;
	logic [oate_pkg::KEY_W-1:0]  key_q;
	logic [oate_pkg::KEY_W-1:0]  tmp_q;
	logic [oate_pkg::ADDR_W-1:0] pa_q;
	logic [oate_pkg::ADDR_W-1:0] cnt_q;
	logic [oate_pkg::ADDR_W-1:0] src_q;
	logic [oate_pkg::ADDR_W-1:0] dst_s1;
	logic                        pend_s1;
	logic [oate_pkg::CNT_W-1:0]  rem_q;
	logic                        down_q;
	logic                        put_q;
	logic                        swap_q;
	logic [oate_pkg::ADDR_W-1:0] lo_q;
	logic [oate_pkg::ADDR_W-1:0] hi_q;
	oate_pkg::status_t           res_status_q;
	logic [oate_pkg::ADDR_W-1:0] res_index_q;

	logic                          m_valid_q;
	oate_pkg::status_t             m_status_q;
	logic [oate_pkg::VAL_W-1:0]    m_value_q;
	logic [oate_pkg::IDX_W-1:0]    m_index_q;
	logic [oate_pkg::CNT_OUT_W-1:0] m_count_q;
	logic                          m_last_q;

	// input fields
	oate_pkg::cmd_t                in_cmd;
	logic [oate_pkg::POS_W-1:0]    in_pos;
	logic [oate_pkg::POSB_W-1:0]   in_posb;
	logic [oate_pkg::KEY_W-1:0]    in_key;

	logic                        accept;
	logic [oate_pkg::CMP_W-1:0]  fill_c, pos_c, posb_c;
	logic                        empty, full;
	logic                        ins_bad, del_bad, swap_bad;
	logic                        ins_ok, del_ok;
	logic                        out_free;
	logic                        disp_last, find_hit, find_end, pair_more;

	// result register load
	logic                         out_load;
	oate_pkg::status_t            out_status;
	logic [oate_pkg::KEY_W-1:0]   out_value;
	logic [oate_pkg::ADDR_W-1:0]  out_index;
	logic                         out_last;

	assign in_cmd  = oate_pkg::cmd_t'(s_tuser);
	assign in_pos  = s_tdata[oate_pkg::POS_W-1:0];
	assign in_posb = s_tdata[oate_pkg::POS_W +: oate_pkg::POSB_W];
	assign in_key  = s_tdata[oate_pkg::POS_W + oate_pkg::POSB_W +: oate_pkg::KEY_W];

	assign s_tready = (state_q == oate_pkg::S_IDLE);
	assign accept   = s_tvalid && s_tready;

	assign fill_c = oate_pkg::CMP_W'(fill_q);
	assign pos_c  = oate_pkg::CMP_W'(in_pos);
	assign posb_c = oate_pkg::CMP_W'(in_posb);
	assign empty  = (fill_q == '0);
	assign full   = (fill_q == oate_pkg::CNT_W'(oate_pkg::DEPTH));

	assign ins_bad  = (pos_c > fill_c);
	assign del_bad  = (pos_c >= fill_c);
	assign swap_bad = (pos_c >= fill_c) || (posb_c >= fill_c);
	assign ins_ok   = accept && (in_cmd == oate_pkg::CMD_INSERT) && !ins_bad && !full;
	assign del_ok   = accept && (in_cmd == oate_pkg::CMD_DELETE) && !del_bad;

	assign out_free  = !m_valid_q || m_tready;
	assign disp_last = ((oate_pkg::CNT_W'(cnt_q) + oate_pkg::CNT_W'(1)) == fill_q);
	assign find_end  = disp_last;
	assign find_hit  = (ram_rdata == key_q);
	assign pair_more = ((oate_pkg::CNT_W'(lo_q) + oate_pkg::CNT_W'(2)) < oate_pkg::CNT_W'(hi_q));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			oate_pkg::S_IDLE: begin
				if (accept) begin
					unique case (in_cmd)
						oate_pkg::CMD_DISPLAY: state_d = empty ? oate_pkg::S_RESP : oate_pkg::S_DISP;
						oate_pkg::CMD_INSERT:  state_d = (ins_bad || full) ? oate_pkg::S_RESP
						                                                  : oate_pkg::S_MOVE;
						oate_pkg::CMD_DELETE:  state_d = del_bad ? oate_pkg::S_RESP : oate_pkg::S_MOVE;
						oate_pkg::CMD_SWAP:    state_d = swap_bad ? oate_pkg::S_RESP : oate_pkg::S_RLO;
						oate_pkg::CMD_REVERSE: state_d = (fill_q < oate_pkg::CNT_W'(2)) ? oate_pkg::S_RESP
						                                                               : oate_pkg::S_RLO;
						oate_pkg::CMD_FIND:    state_d = empty ? oate_pkg::S_RESP : oate_pkg::S_FIND;
						default:               state_d = oate_pkg::S_RESP;
					endcase
				end
			end
			oate_pkg::S_DISP: begin
				if (out_free && disp_last) begin
					state_d = oate_pkg::S_IDLE;
				end
			end
			oate_pkg::S_FIND: begin
				if (find_hit || find_end) begin
					state_d = oate_pkg::S_RESP;
				end
			end
			oate_pkg::S_MOVE: begin
				if (rem_q == '0) begin
					state_d = put_q ? oate_pkg::S_PUT : oate_pkg::S_RESP;
				end
			end
			oate_pkg::S_PUT: state_d = oate_pkg::S_RESP;
			oate_pkg::S_RLO: state_d = oate_pkg::S_RHI;
			oate_pkg::S_RHI: state_d = oate_pkg::S_WLO;
			oate_pkg::S_WLO: state_d = oate_pkg::S_WHI;
			oate_pkg::S_WHI: state_d = (swap_q || !pair_more) ? oate_pkg::S_RESP : oate_pkg::S_RLO;
			oate_pkg::S_RESP: begin
				if (out_free) begin
					state_d = oate_pkg::S_IDLE;
				end
			end
			default: state_d = oate_pkg::S_IDLE;
		endcase
	end

	// memory accesses and result loads
	always_comb begin
		ram_req    = '0;
		out_load   = 1'b0;
		out_status = oate_pkg::ST_OK;
		out_value  = '0;
		out_index  = '0;
		out_last   = 1'b1;
		unique case (state_q)
			oate_pkg::S_IDLE: begin
				// fetch entry 0 early so the walk starts on the next cycle
				if (accept && !empty &&
				    (in_cmd == oate_pkg::CMD_DISPLAY || in_cmd == oate_pkg::CMD_FIND)) begin
					ram_req.re = 1'b1;
				end
			end
			oate_pkg::S_DISP: begin
				if (out_free) begin
					out_load  = 1'b1;
					out_value = ram_rdata;
					out_index = cnt_q;
					out_last  = disp_last;
					if (!disp_last) begin
						ram_req.re    = 1'b1;
						ram_req.raddr = cnt_q + oate_pkg::ADDR_W'(1);
					end
				end
			end
			oate_pkg::S_FIND: begin
				if (!find_hit && !find_end) begin
					ram_req.re    = 1'b1;
					ram_req.raddr = cnt_q + oate_pkg::ADDR_W'(1);
				end
			end
			oate_pkg::S_MOVE: begin
				if (pend_s1) begin
					ram_req.we    = 1'b1;
					ram_req.waddr = dst_s1;
					ram_req.wdata = ram_rdata;
				end
				if (rem_q != '0) begin
					ram_req.re    = 1'b1;
					ram_req.raddr = src_q;
				end
			end
			oate_pkg::S_PUT: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = pa_q;
				ram_req.wdata = key_q;
			end
			oate_pkg::S_RLO: begin
				ram_req.re    = 1'b1;
				ram_req.raddr = lo_q;
			end
			oate_pkg::S_RHI: begin
				ram_req.re    = 1'b1;
				ram_req.raddr = hi_q;
			end
			oate_pkg::S_WLO: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = lo_q;
				ram_req.wdata = ram_rdata;
			end
			oate_pkg::S_WHI: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = hi_q;
				ram_req.wdata = tmp_q;
			end
			oate_pkg::S_RESP: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_status = res_status_q;
					out_index  = res_index_q;
				end
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= oate_pkg::S_IDLE;
			fill_q    <= '0;
			m_valid_q <= 1'b0;
			pend_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ins_ok) begin
				fill_q <= fill_q + oate_pkg::CNT_W'(1);
			end else if (del_ok) begin
				fill_q <= fill_q - oate_pkg::CNT_W'(1);
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			pend_s1 <= (state_q == oate_pkg::S_MOVE) && (rem_q != '0);
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (out_load) begin
			m_status_q <= out_status;
			m_value_q  <= oate_pkg::VAL_W'(out_value);
			m_index_q  <= oate_pkg::IDX_W'(out_index);
			m_count_q  <= oate_pkg::CNT_OUT_W'(fill_q);
			m_last_q   <= out_last;
		end
		unique case (state_q)
			oate_pkg::S_IDLE: begin
				if (accept) begin
					key_q       <= in_key;
					pa_q        <= oate_pkg::ADDR_W'(in_pos);
					swap_q      <= (in_cmd == oate_pkg::CMD_SWAP);
					put_q       <= (in_cmd == oate_pkg::CMD_INSERT);
					down_q      <= (in_cmd == oate_pkg::CMD_INSERT);
					cnt_q       <= '0;
					res_index_q <= '0;
					// insert walks the tail downward, delete walks it upward
					if (in_cmd == oate_pkg::CMD_INSERT) begin
						src_q <= oate_pkg::ADDR_W'(fill_q - oate_pkg::CNT_W'(1));
						rem_q <= fill_q - oate_pkg::CNT_W'(in_pos);
					end else begin
						src_q <= oate_pkg::ADDR_W'(pos_c + oate_pkg::CMP_W'(1));
						rem_q <= fill_q - oate_pkg::CNT_W'(in_pos) - oate_pkg::CNT_W'(1);
					end
					if (in_cmd == oate_pkg::CMD_SWAP) begin
						lo_q <= oate_pkg::ADDR_W'(in_pos);
						hi_q <= oate_pkg::ADDR_W'(in_posb);
					end else begin
						lo_q <= '0;
						hi_q <= oate_pkg::ADDR_W'(fill_q - oate_pkg::CNT_W'(1));
					end
					unique case (in_cmd)
						oate_pkg::CMD_DISPLAY: res_status_q <= oate_pkg::ST_EMPTY;
						oate_pkg::CMD_INSERT:  res_status_q <= ins_bad ? oate_pkg::ST_BADPOS :
						                                       full    ? oate_pkg::ST_FULL
						                                               : oate_pkg::ST_OK;
						oate_pkg::CMD_DELETE:  res_status_q <= del_bad ? oate_pkg::ST_BADPOS
						                                               : oate_pkg::ST_OK;
						oate_pkg::CMD_SWAP:    res_status_q <= swap_bad ? oate_pkg::ST_BADPOS
						                                                : oate_pkg::ST_OK;
						oate_pkg::CMD_REVERSE: res_status_q <= oate_pkg::ST_OK;
						oate_pkg::CMD_FIND:    res_status_q <= oate_pkg::ST_NOTFOUND;
						default:               res_status_q <= oate_pkg::ST_BADCMD;
					endcase
				end
			end
			oate_pkg::S_DISP: begin
				if (out_free && !disp_last) begin
					cnt_q <= cnt_q + oate_pkg::ADDR_W'(1);
				end
			end
			oate_pkg::S_FIND: begin
				if (find_hit) begin
					res_status_q <= oate_pkg::ST_OK;
					res_index_q  <= cnt_q;
				end else if (!find_end) begin
					cnt_q <= cnt_q + oate_pkg::ADDR_W'(1);
				end
			end
			oate_pkg::S_MOVE: begin
				if (rem_q != '0) begin
					rem_q <= rem_q - oate_pkg::CNT_W'(1);
					if (down_q) begin
						dst_s1 <= src_q + oate_pkg::ADDR_W'(1);
						src_q  <= src_q - oate_pkg::ADDR_W'(1);
					end else begin
						dst_s1 <= src_q - oate_pkg::ADDR_W'(1);
						src_q  <= src_q + oate_pkg::ADDR_W'(1);
					end
				end
			end
			oate_pkg::S_RHI: tmp_q <= ram_rdata;
			oate_pkg::S_WHI: begin
				lo_q <= lo_q + oate_pkg::ADDR_W'(1);
				hi_q <= hi_q - oate_pkg::ADDR_W'(1);
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_status_q;
	assign m_tlast  = m_last_q;
	assign m_tdata  = {{(oate_pkg::OUT_DATA_W - oate_pkg::OUT_BITS){1'b0}},
	                   m_count_q, m_index_q, m_value_q};

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= oate_pkg::CNT_W'(oate_pkg::DEPTH))
		else $error("fill count beyond table depth");

	a_no_rw_collide: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_req.we && ram_req.re) |-> (ram_req.waddr != ram_req.raddr))
		else $error("read and write to the same entry in one cycle");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!m_valid_q || m_tready))
		else $error("result beat overwritten before it was taken");

	a_load_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (state_q == oate_pkg::S_DISP || state_q == oate_pkg::S_RESP))
		else $error("result loaded outside display or response");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> (fill_q == $past(fill_q)))
		else $error("fill count changed without a command beat");
`endif

endmodule

// ===== rtl/ordered_array_table_engine.sv =====
// ----------------------------------------------------------------------------
// ordered_array_table_engine: ordered key table with edit and search commands
// Top level: command sequencer and key memory.
// ----------------------------------------------------------------------------
// One command is taken at a time; s_tready is high only while the sequencer is
// idle, and a finished result may still sit in the output register meanwhile.
// Timing is set by the single read and single write port of the key memory:
// display streams the entries in order and waits while the sink stalls, find
// reads entries in order until a hit or the last entry and then responds,
// insert shifts the tail up one entry at a time and then writes the new key,
// delete shifts the tail down one entry at a time, swap reads both entries and
// writes them back exchanged, reverse exchanges pairs from both ends inward,
// and rejected commands go straight to the response.
// The key memory is not cleared after reset; only entries below the fill count
// are ever read.
module ordered_array_table_engine (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// position [5:0], position_b [10:6], key_value [74:11], zero fill
	input  logic [oate_pkg::IN_DATA_W-1:0]    s_tdata,
	// cmd [2:0]
	input  logic [oate_pkg::CMD_W-1:0]        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// read_value [63:0], index [68:64], item_count [74:69], zero fill
	output logic [oate_pkg::OUT_DATA_W-1:0]   m_tdata,
	// status [2:0]
	output logic [oate_pkg::STAT_W-1:0]       m_tuser,
	output logic                              m_tlast
);

	oate_pkg::ram_req_t           ram_req;
	logic [oate_pkg::KEY_W-1:0]   ram_rdata;

	oate_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	oate_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

endmodule
